// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, codes and types of the text console cell writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_READ,
        S_RWAIT,
        S_SCROLL,
        S_BLANK,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  glyph_code;
        logic [7:0]  fill_attribute;
        logic [10:0] cell_index;
    } t_req;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_line;
        logic [15:0] cell_value;
        logic        did_scroll;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ----- rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tcw_engine.sv -----
// ----------------------------------------------------------------------------
// tcw_engine
// sequencer with cursor state and a shared address counter; cell writes and
// reads use cursor/request index; the counter drives scroll and clear sweeps
// ----------------------------------------------------------------------------
module tcw_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  tcw_pkg::t_req                 i_req,
    input  logic [7:0]                    i_attr,
    input  logic                          i_out_free,
    input  logic [15:0]                   i_rdata,
    output logic                          o_idle,
    output logic                          o_done,
    output tcw_pkg::t_result              o_result,
    output tcw_pkg::t_ram_req             o_ram
);

    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_IDX =
        tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] SCROLL_END =
        tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::ADDR_W-1:0] ROW_STEP =
        tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);

    tcw_pkg::t_state             r_state, n_state;
    logic [6:0]                  r_col, n_col;
    logic [4:0]                  r_row, n_row;
    logic [tcw_pkg::ADDR_W-1:0]  r_cnt, n_cnt;
    logic [15:0]                 r_wdata, n_wdata;
    logic                        r_advance, n_advance;
    logic [10:0]                 r_idx, n_idx;
    logic [15:0]                 r_value, n_value;
    logic                        r_scroll, n_scroll;
    logic [7:0]                  r_fill, n_fill;
    logic [tcw_pkg::ADDR_W-1:0]  cur_idx;

    assign cur_idx = tcw_pkg::ADDR_W'(int'(r_row) * tcw_pkg::COLUMNS + int'(r_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_INIT;
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wdata   <= n_wdata;
        r_advance <= n_advance;
        r_idx     <= n_idx;
        r_value   <= n_value;
        r_scroll  <= n_scroll;
        r_fill    <= n_fill;
    end

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_cnt     = r_cnt;
        n_wdata   = r_wdata;
        n_advance = r_advance;
        n_idx     = r_idx;
        n_value   = r_value;
        n_scroll  = r_scroll;
        n_fill    = r_fill;
        o_done    = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = cur_idx;
        o_ram.wdata = r_wdata;
        o_ram.raddr = tcw_pkg::ADDR_W'(r_idx);

        case (r_state)
            tcw_pkg::S_INIT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_cnt;
                o_ram.wdata = {8'h00, tcw_pkg::CH_BLANK};
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::S_IDLE: begin
                if (i_start) begin
                    n_scroll = 1'b0;
                    n_value  = '0;
                    n_idx    = i_req.cell_index;
                    n_fill   = i_req.fill_attribute;
                    n_cnt    = '0;
                    case (i_req.mode)
                        tcw_pkg::MODE_PUT: begin
                            if (i_req.glyph_code == tcw_pkg::CH_NEWLINE) begin
                                n_col = '0;
                                if (int'(r_row) + 1 >= tcw_pkg::ROWS) begin
                                    n_row    = 5'(tcw_pkg::ROWS - 1);
                                    n_scroll = 1'b1;
                                    n_state  = tcw_pkg::S_SCROLL;
                                end else begin
                                    n_row   = r_row + 1'b1;
                                    n_state = tcw_pkg::S_DONE;
                                end
                            end else if (i_req.glyph_code == tcw_pkg::CH_BACKSPACE) begin
                                if (r_col != '0) begin
                                    n_col = r_col - 1'b1;
                                end else if (r_row != '0) begin
                                    n_row = r_row - 1'b1;
                                    n_col = 7'(tcw_pkg::COLUMNS - 1);
                                end
                                n_wdata   = {i_attr, tcw_pkg::CH_BLANK};
                                n_advance = 1'b0;
                                n_state   = tcw_pkg::S_PUT;
                            end else begin
                                n_wdata   = {i_attr, i_req.glyph_code};
                                n_advance = 1'b1;
                                n_state   = tcw_pkg::S_PUT;
                            end
                        end
                        tcw_pkg::MODE_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_state = tcw_pkg::S_CLEAR;
                        end
                        tcw_pkg::MODE_READ: begin
                            if (int'(i_req.cell_index) < tcw_pkg::CELL_COUNT) begin
                                n_state = tcw_pkg::S_READ;
                            end else begin
                                n_state = tcw_pkg::S_DONE;
                            end
                        end
                        default: begin
                            n_state = tcw_pkg::S_DONE;
                        end
                    endcase
                end
            end
            tcw_pkg::S_PUT: begin
                o_ram.we = 1'b1;
                n_state  = tcw_pkg::S_DONE;
                if (r_advance) begin
                    if (int'(r_col) + 1 >= tcw_pkg::COLUMNS) begin
                        n_col = '0;
                        if (int'(r_row) + 1 >= tcw_pkg::ROWS) begin
                            n_row    = 5'(tcw_pkg::ROWS - 1);
                            n_scroll = 1'b1;
                            n_cnt    = '0;
                            n_state  = tcw_pkg::S_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            tcw_pkg::S_READ: begin
                n_state = tcw_pkg::S_RWAIT;
            end
            tcw_pkg::S_RWAIT: begin
                n_value = i_rdata;
                n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_SCROLL: begin
                // read one row ahead of the counter, write the previous read to the slot behind it
                o_ram.raddr = r_cnt + ROW_STEP;
                o_ram.we    = (r_cnt != '0);
                o_ram.waddr = r_cnt - 1'b1;
                o_ram.wdata = i_rdata;
                if (r_cnt == SCROLL_END) begin
                    n_state = tcw_pkg::S_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::S_BLANK: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_cnt;
                o_ram.wdata = {i_attr, tcw_pkg::CH_BLANK};
                if (r_cnt == LAST_IDX) begin
                    n_state = tcw_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_cnt;
                o_ram.wdata = {r_fill, tcw_pkg::CH_BLANK};
                if (r_cnt == LAST_IDX) begin
                    n_state = tcw_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle                 = (r_state == tcw_pkg::S_IDLE);
    assign o_result.cursor_column = r_col;
    assign o_result.cursor_line   = r_row;
    assign o_result.cell_value    = r_value;
    assign o_result.did_scroll    = r_scroll;

endmodule

// ----- rtl/text_console_cell_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer
// text-mode console engine: screen store of glyph/attribute cells and cursor
// ----------------------------------------------------------------------------
// scroll copies the rows up through the single ram port pair
// clear screen sweeps the store with one cell write per cycle
// throughput: one request at a time, tready low until the result is handed off
// reset: synchronous active low; then a blanking sweep of the store with
// tready low, configuration writes still taken
module text_console_cell_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // glyph_code, fill_attribute, cell_index
    input  logic [1:0]  i_s_tuser,  // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // cursor_column, cursor_line, cell_value, did_scroll
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data  // text_attribute
);

    tcw_pkg::t_req      req;
    tcw_pkg::t_result   result;
    tcw_pkg::t_ram_req  ram_req;
    logic [15:0]        rdata;
    logic               s_accept;
    logic               eng_idle;
    logic               eng_done;
    logic               out_free;
    logic [7:0]         r_attr;
    logic               r_out_valid;
    tcw_pkg::t_result   r_out;

    assign req.mode           = i_s_tuser;
    assign req.glyph_code     = i_s_tdata[7:0];
    assign req.fill_attribute = i_s_tdata[15:8];
    assign req.cell_index     = i_s_tdata[26:16];

    assign o_s_tready  = eng_idle;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= 8'd15;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.did_scroll, r_out.cell_value,
                         r_out.cursor_line, r_out.cursor_column};

    tcw_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept),
        .i_req      (req),
        .i_attr     (r_attr),
        .i_out_free (out_free),
        .i_rdata    (rdata),
        .o_idle     (eng_idle),
        .o_done     (eng_done),
        .o_result   (result),
        .o_ram      (ram_req)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !eng_done)
        else $error("result register overwritten while held");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("ready after accepting a request");

    a_ready_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |=> o_s_tready)
        else $error("not ready after handing off a result");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (int'(r_out.cursor_column) < tcw_pkg::COLUMNS) &&
                       (int'(r_out.cursor_line) < tcw_pkg::ROWS))
        else $error("cursor out of screen range");

endmodule
